[design/nvu_pkg.sv]
// Package for the vec3 normalize unit: payload types, lane types and widths.
// Used by the cells, the normalize unit and the testbench; depends on nothing.
`timescale 1ns / 1ps
package nvu_pkg;

  localparam int COMP_W = 16;
  localparam int MAG_W  = 17;
  localparam int SQ_W   = 31;
  localparam int SUM_W  = 32;
  localparam int ROOT_W = 16;
  localparam int REM_W  = 18;
  localparam int NUM_ROOT_CELLS = 16;

  typedef struct packed {
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;
  } vec_in_t;

  typedef struct packed {
    logic signed [15:0] unit_x;
    logic signed [15:0] unit_y;
    logic signed [15:0] unit_z;
    logic [15:0]        length;
    logic               zero_vector;
  } vec_out_t;

  typedef struct packed {
    logic [SUM_W-1:0] rem;
    logic [SUM_W-1:0] quo;
    logic [SUM_W-1:0] dvs;
  } div_lane_t;

  typedef struct packed {
    logic [SUM_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } root_lane_t;

  typedef struct packed {
    logic       valid;
    logic       zero;
    logic [2:0] sgn;
  } side_t;

endpackage

[design/nvu_stream_if.sv]
// Valid/ready stream interface carrying one item of payload type T.
// Depends on nothing; payload types come from nvu_pkg at instantiation.
`timescale 1ns / 1ps
interface nvu_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/nvu_div_cell.sv]
// One restoring division cell: one quotient bit per cell, registered.
// Depends on nvu_pkg.
`timescale 1ns / 1ps
module nvu_div_cell #(
  parameter bit SHIFT = 1'b1
) (
  input  logic               clk,
  input  logic               en,
  input  nvu_pkg::div_lane_t lane_in,
  output nvu_pkg::div_lane_t lane_out
);

  logic [nvu_pkg::SUM_W:0] trial;
  logic [nvu_pkg::SUM_W:0] diff;
  logic                    ge;

  always_comb begin
    trial = SHIFT ? {lane_in.rem, 1'b0} : {1'b0, lane_in.rem};
    ge    = trial >= {1'b0, lane_in.dvs};
    diff  = trial - {1'b0, lane_in.dvs};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out.rem <= ge ? diff[nvu_pkg::SUM_W-1:0] : trial[nvu_pkg::SUM_W-1:0];
      lane_out.quo <= {lane_in.quo[nvu_pkg::SUM_W-2:0], ge};
      lane_out.dvs <= lane_in.dvs;
    end
  end

endmodule

[design/nvu_root_cell.sv]
// One digit-by-digit square root cell: one root bit per cell, registered.
// Depends on nvu_pkg.
`timescale 1ns / 1ps
module nvu_root_cell (
  input  logic                clk,
  input  logic                en,
  input  nvu_pkg::root_lane_t lane_in,
  output nvu_pkg::root_lane_t lane_out
);

  logic [nvu_pkg::REM_W+1:0] shifted;
  logic [nvu_pkg::REM_W+1:0] trial;
  logic [nvu_pkg::REM_W+1:0] diff;
  logic                      ge;

  always_comb begin
    shifted = {lane_in.rem, lane_in.rad[nvu_pkg::SUM_W-1 -: 2]};
    trial   = {2'b00, lane_in.root, 2'b01};
    ge      = shifted >= trial;
    diff    = shifted - trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out.rad  <= {lane_in.rad[nvu_pkg::SUM_W-3:0], 2'b00};
      lane_out.rem  <= ge ? diff[nvu_pkg::REM_W-1:0] : shifted[nvu_pkg::REM_W-1:0];
      lane_out.root <= {lane_in.root[nvu_pkg::ROOT_W-2:0], ge};
    end
  end

endmodule

[design/vec3_normalize_unit.sv]
// Vec3 normalize unit: scales a signed 16-bit vector to unit length in Q1.FRAC_BITS and
// reports floor(sqrt(x*x+y*y+z*z)); a zero vector gives zeros and raises zero_vector.
// One item enters per cycle unless the output stalls; the pipeline holds square and sum stages,
// a chain of 2*FRAC_BITS+1 division cells (one quotient bit each, three lanes), a chain of
// 16 square root cells (one root bit each, four lanes) and an output register. The whole
// chain advances whenever the output register is empty or being taken.
`timescale 1ns / 1ps
module vec3_normalize_unit #(
  parameter int FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst,
  nvu_stream_if.sink   in,
  nvu_stream_if.source out
);

  localparam int DIV_CELLS  = 2 * FRAC_BITS + 1;
  localparam int ROOT_CELLS = nvu_pkg::NUM_ROOT_CELLS;
  localparam int SIDE_LEN   = DIV_CELLS + ROOT_CELLS;

  logic en;

  logic [nvu_pkg::MAG_W-1:0] mag [3];
  logic [nvu_pkg::SQ_W-1:0]  sq0 [3];
  nvu_pkg::side_t            side0;
  logic [nvu_pkg::SQ_W-1:0]  sq1 [3];
  logic [nvu_pkg::SUM_W-1:0] sum1;
  nvu_pkg::side_t            side1;
  nvu_pkg::side_t            side [SIDE_LEN];

  nvu_pkg::div_lane_t  div_lane  [3][DIV_CELLS+1];
  nvu_pkg::root_lane_t root_lane [4][ROOT_CELLS+1];

  nvu_pkg::side_t last_side;
  logic [nvu_pkg::ROOT_W-1:0] root_mag [3];

  assign en = !out.valid || out.ready;
  assign in.ready = en;

  always_comb begin
    mag[0] = in.data.vec_x[15] ? 17'(17'd0 - {in.data.vec_x[15], in.data.vec_x})
                               : {1'b0, in.data.vec_x};
    mag[1] = in.data.vec_y[15] ? 17'(17'd0 - {in.data.vec_y[15], in.data.vec_y})
                               : {1'b0, in.data.vec_y};
    mag[2] = in.data.vec_z[15] ? 17'(17'd0 - {in.data.vec_z[15], in.data.vec_z})
                               : {1'b0, in.data.vec_z};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq0[i] <= nvu_pkg::SQ_W'(mag[i] * mag[i]);
        sq1[i] <= sq0[i];
      end
      sum1 <= nvu_pkg::SUM_W'(sq0[0]) + nvu_pkg::SUM_W'(sq0[1]) + nvu_pkg::SUM_W'(sq0[2]);
      side0.zero  <= (in.data == '0);
      side0.sgn   <= {in.data.vec_z[15], in.data.vec_y[15], in.data.vec_x[15]};
      side1.zero  <= side0.zero;
      side1.sgn   <= side0.sgn;
      side[0].zero <= side1.zero;
      side[0].sgn  <= side1.sgn;
      for (int k = 1; k < SIDE_LEN; k++) begin
        side[k].zero <= side[k-1].zero;
        side[k].sgn  <= side[k-1].sgn;
      end
    end
    if (rst) begin
      side0.valid <= 1'b0;
      side1.valid <= 1'b0;
      for (int k = 0; k < SIDE_LEN; k++) begin
        side[k].valid <= 1'b0;
      end
    end else if (en) begin
      side0.valid <= in.valid;
      side1.valid <= side0.valid;
      side[0].valid <= side1.valid;
      for (int k = 1; k < SIDE_LEN; k++) begin
        side[k].valid <= side[k-1].valid;
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_div_lane
    assign div_lane[l][0].rem = nvu_pkg::SUM_W'(sq1[l]);
    assign div_lane[l][0].quo = '0;
    assign div_lane[l][0].dvs = sum1;
    for (genvar k = 0; k < DIV_CELLS; k++) begin : g_cell
      nvu_div_cell #(.SHIFT(k != 0)) u_cell (
        .clk      (clk),
        .en       (en),
        .lane_in  (div_lane[l][k]),
        .lane_out (div_lane[l][k+1])
      );
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_root_lane
    if (l < 3) begin : g_unit
      assign root_lane[l][0].rad = div_lane[l][DIV_CELLS].quo;
    end else begin : g_len
      assign root_lane[l][0].rad = div_lane[0][DIV_CELLS].dvs;
    end
    assign root_lane[l][0].rem  = '0;
    assign root_lane[l][0].root = '0;
    for (genvar k = 0; k < ROOT_CELLS; k++) begin : g_cell
      nvu_root_cell u_cell (
        .clk      (clk),
        .en       (en),
        .lane_in  (root_lane[l][k]),
        .lane_out (root_lane[l][k+1])
      );
    end
  end

  assign last_side = side[SIDE_LEN-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      root_mag[i] = last_side.zero ? '0 : root_lane[i][ROOT_CELLS].root;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out.data.unit_x <= last_side.sgn[0] ? 16'(16'd0 - root_mag[0]) : root_mag[0];
      out.data.unit_y <= last_side.sgn[1] ? 16'(16'd0 - root_mag[1]) : root_mag[1];
      out.data.unit_z <= last_side.sgn[2] ? 16'(16'd0 - root_mag[2]) : root_mag[2];
      out.data.length <= last_side.zero ? '0 : root_lane[3][ROOT_CELLS].root;
      out.data.zero_vector <= last_side.zero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (en) begin
      out.valid <= last_side.valid;
    end
  end

`ifndef NO_ASSERTIONS
  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> (out.data.zero_vector == (out.data.length == '0)))
    else $error("zero flag disagrees with length");
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> ($signed(out.data.unit_x) <= $signed(17'(1 << FRAC_BITS)) &&
                   $signed(out.data.unit_x) >= -$signed(17'(1 << FRAC_BITS))))
    else $error("unit component out of range");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |-> !in.ready)
    else $error("input taken while output stalled");
`endif

endmodule

[test/testbench.sv]
// Testbench for vec3_normalize_unit: directed and random vectors through the stream ports,
// checked against a fixed-point normalization predictor. Depends on nvu_pkg, nvu_stream_if.
`timescale 1ns / 1ps
module testbench;

  localparam int FRAC = 14;
  localparam int LATENCY = 2 * FRAC + 21;
  localparam longint CYCLE_LIMIT = 400000;

  class norm_scoreboard;
    nvu_pkg::vec_out_t pending[$];
    int errors;
    int checked;
    int zeros;
    int full_scale;

    function new();
      errors = 0;
      checked = 0;
      zeros = 0;
      full_scale = 0;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
        b = r | (64'd1 << i);
        if (b * b <= v) r = b;
      end
      return r;
    endfunction

    function automatic logic [15:0] unit_of(logic signed [15:0] c, longint unsigned s);
      longint unsigned m;
      longint unsigned q;
      logic [15:0] r;
      m = (c < 0) ? -longint'(c) : longint'(c);
      q = ((m * m) << (2 * FRAC)) / s;
      r = 16'(int_sqrt(q));
      return (c < 0) ? 16'(16'd0 - r) : r;
    endfunction

    function void note_vector(nvu_pkg::vec_in_t v);
      nvu_pkg::vec_out_t e;
      longint unsigned s;
      s = longint'(v.vec_x) * v.vec_x + longint'(v.vec_y) * v.vec_y
          + longint'(v.vec_z) * v.vec_z;
      e = '0;
      if (s == 0) begin
        e.zero_vector = 1'b1;
      end else begin
        e.unit_x = unit_of(v.vec_x, s);
        e.unit_y = unit_of(v.vec_y, s);
        e.unit_z = unit_of(v.vec_z, s);
        e.length = 16'(int_sqrt(s));
      end
      pending.push_back(e);
    endfunction

    function void check_result(nvu_pkg::vec_out_t a);
      nvu_pkg::vec_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %p", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.zero_vector) zeros++;
      if (a.unit_x == 16384 || a.unit_x == -16384) full_scale++;
      if (a.unit_x !== e.unit_x) begin
        $error("unit_x expected %0d got %0d", e.unit_x, a.unit_x); errors++;
      end
      if (a.unit_y !== e.unit_y) begin
        $error("unit_y expected %0d got %0d", e.unit_y, a.unit_y); errors++;
      end
      if (a.unit_z !== e.unit_z) begin
        $error("unit_z expected %0d got %0d", e.unit_z, a.unit_z); errors++;
      end
      if (a.length !== e.length) begin
        $error("length expected %0d got %0d", e.length, a.length); errors++;
      end
      if (a.zero_vector !== e.zero_vector) begin
        $error("zero_vector expected %0b got %0b", e.zero_vector, a.zero_vector);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  longint cycles = 0;
  bit calm = 1'b0;
  int hold_off = 0;
  norm_scoreboard sb = new();

  nvu_stream_if #(nvu_pkg::vec_in_t) in_if ();
  nvu_stream_if #(nvu_pkg::vec_out_t) out_if ();

  vec3_normalize_unit #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk),
    .rst(rst),
    .in(in_if.sink),
    .out(out_if.source)
  );

  always #4 clk = ~clk;

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_if.valid && out_if.ready) sb.check_result(out_if.data);
    if (cycles > CYCLE_LIMIT) begin
      $display("[vec3_normalize_unit] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm || ($urandom_range(99) >= 16);
    end
  end

  task automatic send_vector(nvu_pkg::vec_in_t v);
    while (!calm && $urandom_range(99) < 16) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= v;
    do @(posedge clk); while (!in_if.ready);
    sb.note_vector(v);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_comp();
    case ($urandom_range(5))
      0: return 16'(16'h8000 | $urandom_range(3));
      1: return 16'(16'h7fff - $urandom_range(3));
      2: return 16'($urandom_range(15) - 8);
      3: return 16'($urandom_range(511) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  initial begin
    nvu_pkg::vec_in_t v;
    nvu_pkg::vec_in_t edges[$];
    edges = '{
      '{0, 0, 0}, '{16'sh7fff, 0, 0}, '{-16'sh8000, 0, 0}, '{0, 16'sh7fff, 0},
      '{0, -16'sh8000, 0}, '{0, 0, 16'sh7fff}, '{0, 0, -16'sh8000},
      '{-16'sh8000, -16'sh8000, -16'sh8000}, '{16'sh7fff, 16'sh7fff, 16'sh7fff},
      '{1, 0, 0}, '{-1, 0, 0}, '{1, 1, 1}, '{-1, -1, -1}, '{3, 4, 0}, '{-3, 0, 4},
      '{16'sh7fff, -16'sh8000, 1}, '{-16'sh5555, 16'sh2aaa, -16'sh1}
    };
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (edges[i]) send_vector(edges[i]);
    drain();
    hold_off = 300;
    for (int i = 0; i < 1500; i++) begin
      calm = (i >= 600 && i < 900);
      v.vec_x = pick_comp();
      v.vec_y = pick_comp();
      v.vec_z = pick_comp();
      send_vector(v);
      if (i == 1000) drain();
    end
    drain();
    $display("checked %0d results, %0d zero vectors, %0d full-scale x components",
             sb.checked, sb.zeros, sb.full_scale);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[vec3_normalize_unit] OK");
    end else begin
      $display("[vec3_normalize_unit] ERROR");
    end
    $finish;
  end
endmodule
